>>> rtl/ifp_pkg.sv
// Package for the integer format printer.
// Holds shared constants, character codes, enums and the divider request type.
// No dependencies.
package ifp_pkg;

  localparam int MAX_DIGITS = 20;
  localparam int ND_W       = 5;
  localparam int POS_W      = 32;
  localparam int DEC_BASE   = 10;
  localparam int DIV_BITS   = 8;
  localparam int DIV_STEPS  = 64 / DIV_BITS;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_PCT,
    MODE_LONG
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIT,
    S_SIGN,
    S_DSTART,
    S_DWAIT,
    S_EMIT,
    S_TERM
  } state_t;

  typedef struct packed {
    logic start;
    logic hex;
  } div_req_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    if (d < 4'(DEC_BASE)) begin
      g = CH_ZERO + 8'(d);
    end else begin
      g = CH_A + 8'(d) - 8'(DEC_BASE);
    end
    return g;
  endfunction

endpackage

>>> rtl/ifp_channels.sv
// Channel interfaces of the integer format printer: format input,
// character output and buffer size configuration.
// Depends on nothing.
interface ifp_fmt_if;
  logic        valid;
  logic        ready;
  logic [7:0]  fmt_char;
  logic [63:0] arg_value;
  logic        format_end;

  modport source (output valid, fmt_char, arg_value, format_end, input ready);
  modport sink (input valid, fmt_char, arg_value, format_end, output ready);
endinterface

interface ifp_char_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic [31:0] position;
  logic        stored;
  logic        is_terminator;
  logic        last_of_run;
  logic [31:0] total_length;

  modport source (output valid, out_char, position, stored, is_terminator, last_of_run,
                  total_length, input ready);
  modport sink (input valid, out_char, position, stored, is_terminator, last_of_run,
                total_length, output ready);
endinterface

interface ifp_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] buffer_size;

  modport source (output valid, buffer_size, input ready);
  modport sink (input valid, buffer_size, output ready);
endinterface

>>> rtl/ifp_divider.sv
// Shared digit unit: one hex digit by a four-bit shift, or one decimal digit by
// restoring division by ten, eight quotient bits per cycle.
// Depends on ifp_pkg.
module ifp_divider
  import ifp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  input  logic [63:0] value,
  output logic        done,
  output logic [63:0] quotient,
  output logic [3:0]  digit
);

  logic [63:0]         sh;
  logic [3:0]          rem;
  logic [STEP_W-1:0]   step;
  logic                run;
  logic [4:0]          r5;
  logic [3:0]          r;
  logic [DIV_BITS-1:0] qbyte;

  always_comb begin
    r = rem;
    r5 = '0;
    qbyte = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      r5 = {r, sh[63-i]};
      if (r5 >= 5'(DEC_BASE)) begin
        r5 = r5 - 5'(DEC_BASE);
        qbyte[DIV_BITS-1-i] = 1'b1;
      end
      r = r5[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.hex) begin
          sh   <= {4'd0, value[63:4]};
          rem  <= value[3:0];
          done <= 1'b1;
        end else begin
          sh   <= value;
          rem  <= '0;
          step <= '0;
          run  <= 1'b1;
        end
      end else if (run) begin
        sh   <= {sh[63-DIV_BITS:0], qbyte};
        rem  <= r;
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = sh;
  assign digit    = rem;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !run)
    else $error("divider restarted while busy");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    run && step == STEP_W'(DIV_STEPS - 1) |=> done)
    else $error("divider missed its last step");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !run)
    else $error("divider done while still running");
`endif

endmodule

>>> rtl/integer_format_printer.sv
// Top level of the integer format printer: parse sequencer, digit store and
// output register around the shared digit unit.
// Depends on ifp_pkg, ifp_channels and ifp_divider.
//
// Usage: format bytes enter on fmt, one transaction per byte, with the
// argument bits alongside; format_end closes the string. Every produced
// character leaves as one transaction on chars with its position, stored
// flag and running length; last_of_run marks the final one of a byte.
// cfg writes buffer_size and is always ready; write it only while idle.
// fmt is ready only while the sequencer is idle, so one byte is handled at
// a time. A literal byte passes through S_LIT; '%' and 'l' only set the
// mode. A conversion passes through S_SIGN for a negative value, then
// S_DSTART and S_DWAIT per digit (the digit unit yields 8 quotient bits a
// cycle for a decimal digit), then S_EMIT per character out. The end
// transaction passes through S_TERM.
// Reset clears state, mode, count, buffer_size and the output valid flag; the
// digit store and output data are not cleared. When chars stalls, the sequencer holds on its next
// character until the output register is taken.
module integer_format_printer
  import ifp_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input logic         clk,
  input logic         rst,
  ifp_fmt_if.sink     fmt,
  ifp_char_if.source  chars,
  ifp_cfg_if.sink     cfg
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  state_t                state, state_next;
  mode_t                 mode, mode_next;
  logic [COUNT_BITS-1:0] cnt, cnt_next;
  logic [63:0]           work, work_next;
  logic                  hex_r, hex_next;
  logic [ND_W-1:0]       nd, nd_next;
  logic [7:0]            lit, lit_next;
  logic [30:0]           bsize;
  logic [3:0]            digits [MAX_DIGITS];
  logic                  dig_we;

  logic        ovld, ovld_next;
  logic [7:0]  ochar, ochar_next;
  logic [31:0] opos, opos_next;
  logic        ost, ost_next;
  logic        oterm, oterm_next;
  logic        olast, olast_next;
  logic [31:0] ototal, ototal_next;

  div_req_t    dreq;
  logic        div_done;
  logic [63:0] div_q;
  logic [3:0]  div_digit;

  logic                  slot_free;
  logic [31:0]           bsz32, cnt32, inc32;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [31:0]           low_neg;
  logic [63:0]           wide_neg;
  logic [ND_W-1:0]       nd_inc, nd_dec;

  ifp_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .value    (work),
    .done     (div_done),
    .quotient (div_q),
    .digit    (div_digit)
  );

  assign slot_free = !ovld || chars.ready;
  assign bsz32     = {1'b0, bsize};
  assign cnt32     = 32'(cnt);
  assign cnt_inc   = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
  assign inc32     = 32'(cnt_inc);
  assign low_neg   = 32'd0 - fmt.arg_value[31:0];
  assign wide_neg  = 64'd0 - fmt.arg_value;
  assign nd_inc    = nd + 1'b1;
  assign nd_dec    = nd - 1'b1;

  always_comb begin
    state_next  = state;
    mode_next   = mode;
    cnt_next    = cnt;
    work_next   = work;
    hex_next    = hex_r;
    nd_next     = nd;
    lit_next    = lit;
    dig_we      = 1'b0;
    dreq        = '0;
    ovld_next   = ovld && !chars.ready;
    ochar_next  = ochar;
    opos_next   = opos;
    ost_next    = ost;
    oterm_next  = oterm;
    olast_next  = olast;
    ototal_next = ototal;

    case (state)
      S_IDLE: begin
        if (fmt.valid) begin
          nd_next = '0;
          if (fmt.format_end) begin
            state_next = S_TERM;
          end else begin
            case (mode)
              MODE_TEXT: begin
                if (fmt.fmt_char == CH_PCT) begin
                  mode_next = MODE_PCT;
                end else begin
                  lit_next   = fmt.fmt_char;
                  state_next = S_LIT;
                end
              end
              MODE_PCT: begin
                mode_next = MODE_TEXT;
                if (fmt.fmt_char == CH_D || fmt.fmt_char == CH_I) begin
                  hex_next   = 1'b0;
                  work_next  = fmt.arg_value[31] ? 64'(low_neg) : 64'(fmt.arg_value[31:0]);
                  state_next = fmt.arg_value[31] ? S_SIGN : S_DSTART;
                end else if (fmt.fmt_char == CH_X) begin
                  hex_next   = 1'b1;
                  work_next  = 64'(fmt.arg_value[31:0]);
                  state_next = S_DSTART;
                end else if (fmt.fmt_char == CH_L) begin
                  mode_next = MODE_LONG;
                end
              end
              MODE_LONG: begin
                mode_next = MODE_TEXT;
                if (fmt.fmt_char == CH_D || fmt.fmt_char == CH_I) begin
                  hex_next   = 1'b0;
                  work_next  = fmt.arg_value[63] ? wide_neg : fmt.arg_value;
                  state_next = fmt.arg_value[63] ? S_SIGN : S_DSTART;
                end else if (fmt.fmt_char == CH_X) begin
                  hex_next   = 1'b1;
                  work_next  = fmt.arg_value;
                  state_next = S_DSTART;
                end
              end
              default: mode_next = MODE_TEXT;
            endcase
          end
        end
      end
      S_LIT, S_SIGN, S_EMIT: begin
        if (slot_free) begin
          ovld_next   = 1'b1;
          opos_next   = cnt32;
          ost_next    = cnt32 < bsz32;
          oterm_next  = 1'b0;
          ototal_next = inc32;
          cnt_next    = cnt_inc;
          if (state == S_LIT) begin
            ochar_next = lit;
            olast_next = 1'b1;
            state_next = S_IDLE;
          end else if (state == S_SIGN) begin
            ochar_next = CH_MINUS;
            olast_next = 1'b0;
            state_next = S_DSTART;
          end else begin
            ochar_next = glyph(digits[nd_dec]);
            olast_next = (nd == ND_W'(1));
            nd_next    = nd_dec;
            if (nd == ND_W'(1)) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      S_DSTART: begin
        dreq.start = 1'b1;
        dreq.hex   = hex_r;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          dig_we    = 1'b1;
          work_next = div_q;
          nd_next   = nd_inc;
          if (div_q != 64'd0 && nd_inc < ND_W'(MAX_DIGITS)) begin
            state_next = S_DSTART;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_TERM: begin
        if (slot_free) begin
          ovld_next   = 1'b1;
          ochar_next  = CH_NUL;
          oterm_next  = 1'b1;
          olast_next  = 1'b1;
          ototal_next = cnt32;
          if (cnt32 < bsz32) begin
            opos_next = cnt32;
            ost_next  = 1'b1;
          end else if (bsize != 31'd0) begin
            opos_next = bsz32 - 32'd1;
            ost_next  = 1'b1;
          end else begin
            opos_next = cnt32;
            ost_next  = 1'b0;
          end
          cnt_next   = '0;
          mode_next  = MODE_TEXT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_TEXT;
      cnt   <= '0;
      work  <= '0;
      hex_r <= 1'b0;
      nd    <= '0;
      bsize <= '0;
      ovld  <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      cnt   <= cnt_next;
      work  <= work_next;
      hex_r <= hex_next;
      nd    <= nd_next;
      ovld  <= ovld_next;
      if (cfg.valid) begin
        bsize <= cfg.buffer_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    lit    <= lit_next;
    ochar  <= ochar_next;
    opos   <= opos_next;
    ost    <= ost_next;
    oterm  <= oterm_next;
    olast  <= olast_next;
    ototal <= ototal_next;
    if (dig_we) begin
      digits[nd] <= div_digit;
    end
  end

  assign fmt.ready           = (state == S_IDLE);
  assign cfg.ready           = 1'b1;
  assign chars.valid         = ovld;
  assign chars.out_char      = ochar;
  assign chars.position      = opos;
  assign chars.stored        = ost;
  assign chars.is_terminator = oterm;
  assign chars.last_of_run   = olast;
  assign chars.total_length  = ototal;

`ifndef ASSERT_OFF
  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> nd != '0)
    else $error("digit output with empty store");
  a_nd_bound: assert property (@(posedge clk) disable iff (rst)
    nd <= ND_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");
  a_long_after_pct: assert property (@(posedge clk) disable iff (rst)
    $rose(mode == MODE_LONG) |-> $past(mode) == MODE_PCT)
    else $error("long mode entered without a pending percent");
  a_dec_digit: assert property (@(posedge clk) disable iff (rst)
    state == S_DWAIT && div_done && !hex_r |-> div_digit < 4'(DEC_BASE))
    else $error("decimal digit out of range");
`endif

endmodule
